// File: src/ppuvb_pkg.sv
package ppuvb_pkg;

   // Default sizes of the two memories.
   localparam int DEF_PATTERN_BYTES = 8192;
   localparam int DEF_PAGE_COUNT    = 4;

   // Each nametable page is a fixed 1 KB.
   localparam int PAGE_BYTES       = 1024;
   localparam int PAGE_OFFSET_BITS = 10;

   // Video bus address map.
   localparam logic [13:0] MIRROR_REGION_BASE = 14'h3000;
   localparam logic [13:0] MIRROR_FOLD_STRIDE = 14'h1000;
   localparam logic [13:0] NAMETABLE_BASE     = 14'h2000;

   // Nametable mirroring modes.
   localparam logic [2:0] MIRROR_HORIZONTAL = 3'd0;
   localparam logic [2:0] MIRROR_VERTICAL   = 3'd1;
   localparam logic [2:0] MIRROR_FOUR       = 3'd2;
   localparam logic [2:0] MIRROR_PAGE_A     = 3'd3;
   localparam logic [2:0] MIRROR_PAGE_B     = 3'd4;

   // What the responder does with the data bus.
   typedef enum logic [1:0] {
      BUS_HOLD    = 2'd0,
      BUS_DRIVE   = 2'd1,
      BUS_RELEASE = 2'd2
   } bus_action_type;

   // One sample of the bus pins.
   typedef struct packed {
      logic        latch_enable;
      logic        read_n;
      logic        write_n;
      logic [13:0] bus_address;
      logic [7:0]  data_in;
   } req_payload_type;

   // One response to a pin sample.
   typedef struct packed {
      bus_action_type bus_action;
      logic [7:0]     data_out;
   } rsp_payload_type;

   // Decoded memory location for one bus address.
   typedef struct packed {
      logic        to_pattern;
      logic [12:0] pattern_index;
      logic [11:0] nametable_index;
   } mem_select_type;

endpackage

// File: src/ppuvb_ram.sv
module ppuvb_ram
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 1024
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ppuvb_addr_map.sv
module ppuvb_addr_map
   import ppuvb_pkg::*;
   #(
      parameter int PATTERN_BYTES = DEF_PATTERN_BYTES,
      parameter int PAGE_COUNT    = DEF_PAGE_COUNT
   )
   (
      input  logic [13:0]    address,
      input  logic [2:0]     mirror_mode,
      output mem_select_type select
   );

   logic [13:0] folded;
   logic [16:0] remainder;
   logic [1:0]  page;
   logic [1:0]  page_wrapped;

   always_comb begin
      // Addresses from 0x3000 mirror the nametable region below them.
      if (address >= MIRROR_REGION_BASE) begin
         folded = address - MIRROR_FOLD_STRIDE;
      end else begin
         folded = address;
      end

      // Pattern index modulo the pattern size; the quotient is under sixteen.
      remainder = {4'b0000, folded[12:0]};
      for (int k = 3; k >= 0; k--) begin
         if (remainder >= (17'(PATTERN_BYTES) << k)) begin
            remainder = remainder - (17'(PATTERN_BYTES) << k);
         end
      end

      // Nametable page from the mirroring mode.
      case (mirror_mode)
         MIRROR_HORIZONTAL: page = {1'b0, folded[11]};
         MIRROR_VERTICAL:   page = {1'b0, folded[10]};
         MIRROR_FOUR:       page = folded[11:10];
         MIRROR_PAGE_B:     page = 2'd1;
         default:           page = 2'd0;
      endcase

      // Fold a page number past the last page back to the start.
      if ({1'b0, page} >= 3'(PAGE_COUNT)) begin
         page_wrapped = page - 2'(PAGE_COUNT);
      end else begin
         page_wrapped = page;
      end

      select.to_pattern      = (folded < NAMETABLE_BASE);
      select.pattern_index   = remainder[12:0];
      select.nametable_index = {page_wrapped, folded[PAGE_OFFSET_BITS-1:0]};
   end

endmodule

// File: src/ppu_video_bus_memory_responder_unit.sv
// Channel   | Ports                               | Role
// ----------+-------------------------------------+-----------------------------------
// request   | req_valid, req_ready, req_payload   | one sample of the bus pins
// response  | rsp_valid, rsp_ready, rsp_payload   | bus action and read byte per sample
// control   | csr_write_enable, csr_write_data    | nametable mirroring mode
//
// One request is accepted per cycle while no clear runs and the pipe is not stalled;
// its response passes the registered memory read, then the output register.
// After reset both memories are zeroed, one address per cycle, up to the larger
// of PATTERN_BYTES and PAGE_COUNT * 1024 addresses; no request is taken meanwhile.
// A stalled response holds; one more request is still taken behind it.
module ppu_video_bus_memory_responder_unit
   import ppuvb_pkg::*;
   #(
      parameter int PATTERN_BYTES = DEF_PATTERN_BYTES,
      parameter int PAGE_COUNT    = DEF_PAGE_COUNT
   )
   (
      input  logic            clock,
      input  logic            reset,
      input  logic            req_valid,
      output logic            req_ready,
      input  req_payload_type req_payload,
      output logic            rsp_valid,
      input  logic            rsp_ready,
      output rsp_payload_type rsp_payload,
      input  logic            csr_write_enable,
      input  logic [2:0]      csr_write_data
   );

   localparam int NT_BYTES  = PAGE_COUNT * PAGE_BYTES;
   localparam int PAT_AW    = $clog2(PATTERN_BYTES);
   localparam int NT_AW     = $clog2(NT_BYTES);
   localparam int CLEAR_LEN = (PATTERN_BYTES > NT_BYTES) ? PATTERN_BYTES : NT_BYTES;
   localparam int CLR_AW    = $clog2(CLEAR_LEN);

   // Control and bus state.
   logic [2:0]         mode_ff;
   logic [13:0]        latched_ff, latched_in;
   logic [7:0]         captured_ff, captured_in;
   logic               prev_le_ff, prev_rd_ff, prev_wr_ff;
   logic               clear_busy_ff;
   logic [CLR_AW-1:0]  clear_idx_ff;

   // Pipeline registers.
   logic               a_valid_ff, a_valid_in;
   bus_action_type     a_action_ff, a_action_in;
   logic               a_pattern_ff;
   logic               b_valid_ff, b_valid_in;
   rsp_payload_type    b_payload_ff, b_payload_in;

   logic               accept, a_move;
   logic               le_rise, rd_fall, rd_rise, wr_rise;
   mem_select_type     select;

   logic               pat_wr_en, nt_wr_en;
   logic [PAT_AW-1:0]  pat_wr_addr;
   logic [NT_AW-1:0]   nt_wr_addr;
   logic [7:0]         mem_wr_data;
   logic [7:0]         pat_rd_data, nt_rd_data;

   // Handshake: stage A is free or passing its result on.
   assign a_move    = a_valid_ff && (!b_valid_ff || rsp_ready);
   assign req_ready = !clear_busy_ff && (!a_valid_ff || a_move);
   assign accept    = req_valid && req_ready;

   // Pin edge detection and the updated address and data latches.
   always_comb begin
      le_rise = !prev_le_ff && req_payload.latch_enable;
      rd_fall = prev_rd_ff && !req_payload.read_n;
      rd_rise = !prev_rd_ff && req_payload.read_n;
      wr_rise = !prev_wr_ff && req_payload.write_n;

      latched_in = le_rise ? req_payload.bus_address : latched_ff;

      if (!req_payload.read_n || !req_payload.write_n) begin
         captured_in = req_payload.data_in;
      end else begin
         captured_in = captured_ff;
      end

      if (rd_fall) begin
         a_action_in = BUS_DRIVE;
      end else if (rd_rise) begin
         a_action_in = BUS_RELEASE;
      end else begin
         a_action_in = BUS_HOLD;
      end
   end

   ppuvb_addr_map
      #(
         .PATTERN_BYTES (PATTERN_BYTES),
         .PAGE_COUNT    (PAGE_COUNT)
      )
      u_addr_map
      (
         .address     (latched_in),
         .mirror_mode (mode_ff),
         .select      (select)
      );

   // Memory write port: the clearing sweep, then stores on a rising /WR.
   always_comb begin
      if (clear_busy_ff) begin
         pat_wr_en   = ({1'b0, clear_idx_ff} < (CLR_AW+1)'(PATTERN_BYTES));
         nt_wr_en    = ({1'b0, clear_idx_ff} < (CLR_AW+1)'(NT_BYTES));
         pat_wr_addr = clear_idx_ff[PAT_AW-1:0];
         nt_wr_addr  = clear_idx_ff[NT_AW-1:0];
         mem_wr_data = 8'd0;
      end else begin
         pat_wr_en   = accept && wr_rise && select.to_pattern;
         nt_wr_en    = accept && wr_rise && !select.to_pattern;
         pat_wr_addr = select.pattern_index[PAT_AW-1:0];
         nt_wr_addr  = select.nametable_index[NT_AW-1:0];
         mem_wr_data = captured_in;
      end
   end

   ppuvb_ram
      #(
         .WIDTH (8),
         .DEPTH (PATTERN_BYTES)
      )
      u_pattern_ram
      (
         .clock   (clock),
         .wr_en   (pat_wr_en),
         .wr_addr (pat_wr_addr),
         .wr_data (mem_wr_data),
         .rd_en   (accept),
         .rd_addr (select.pattern_index[PAT_AW-1:0]),
         .rd_data (pat_rd_data)
      );

   ppuvb_ram
      #(
         .WIDTH (8),
         .DEPTH (NT_BYTES)
      )
      u_nametable_ram
      (
         .clock   (clock),
         .wr_en   (nt_wr_en),
         .wr_addr (nt_wr_addr),
         .wr_data (mem_wr_data),
         .rd_en   (accept),
         .rd_addr (select.nametable_index[NT_AW-1:0]),
         .rd_data (nt_rd_data)
      );

   // Next pipeline contents; the read byte shows only when driving.
   always_comb begin
      a_valid_in = accept || (a_valid_ff && !a_move);
      b_valid_in = a_move || (b_valid_ff && !rsp_ready);

      b_payload_in.bus_action = a_action_ff;
      if (a_action_ff == BUS_DRIVE) begin
         b_payload_in.data_out = a_pattern_ff ? pat_rd_data : nt_rd_data;
      end else begin
         b_payload_in.data_out = 8'd0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MIRROR_HORIZONTAL;
         latched_ff    <= 14'd0;
         captured_ff   <= 8'd0;
         prev_le_ff    <= 1'b0;
         prev_rd_ff    <= 1'b1;
         prev_wr_ff    <= 1'b1;
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (clear_busy_ff) begin
            clear_idx_ff <= clear_idx_ff + 1'b1;
            if (clear_idx_ff == CLR_AW'(CLEAR_LEN - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
         if (accept) begin
            latched_ff  <= latched_in;
            captured_ff <= captured_in;
            prev_le_ff  <= req_payload.latch_enable;
            prev_rd_ff  <= req_payload.read_n;
            prev_wr_ff  <= req_payload.write_n;
         end
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_action_ff  <= a_action_in;
         a_pattern_ff <= select.to_pattern;
      end
      if (a_move) begin
         b_payload_ff <= b_payload_in;
      end
   end

   assign rsp_valid   = b_valid_ff;
   assign rsp_payload = b_payload_ff;

endmodule
